>>> rtl/core/npcs_pkg.sv
// shared constants and control types for the nearest palette color search unit
`default_nettype none

package npcs_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
  localparam int COLOR_W       = 8;
  localparam int INDEX_W       = 8;
  localparam int SIZE_W        = 9;
  localparam int SQ_W          = 2 * COLOR_W;
  localparam int DIST_W        = 18;
  localparam int ENTRY_W       = 3 * COLOR_W;

  // largest number of entries one query may search
  localparam int SEARCH_MAX    = (PALETTE_DEPTH < 256) ? PALETTE_DEPTH : 256;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);
  localparam logic [SIZE_W-1:0] SIZE_LIMIT = SIZE_W'(SEARCH_MAX);
  localparam logic [ADDR_W-1:0] LAST_MAX   = ADDR_W'(SEARCH_MAX - 1);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic              load_we;
    logic              query_capture;
    logic              rd_en;
    logic              rd_first;
    logic              rd_last;
    logic [ADDR_W-1:0] rd_addr;
    logic              publish;
  } ctl_cmd_t;

  typedef struct packed {
    logic              scan_done;
    logic              out_free;
    logic [ADDR_W-1:0] last_addr;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/core/npcs_if.sv
// valid/ready channel interfaces for query/load items and search results
`default_nettype none

interface npcs_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] entry_index;
  logic [7:0] entry_red;
  logic [7:0] entry_green;
  logic [7:0] entry_blue;
  logic [7:0] query_red;
  logic [7:0] query_green;
  logic [7:0] query_blue;

  modport source (
    output valid, command, entry_index, entry_red, entry_green, entry_blue,
           query_red, query_green, query_blue,
    input  ready
  );
  modport sink (
    input  valid, command, entry_index, entry_red, entry_green, entry_blue,
           query_red, query_green, query_blue,
    output ready
  );
endinterface

interface npcs_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  nearest_index;
  logic [17:0] nearest_distance;

  modport source (
    output valid, nearest_index, nearest_distance,
    input  ready
  );
  modport sink (
    input  valid, nearest_index, nearest_distance,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/npcs_ctrl.sv
// sequencer: accepts items, walks the palette addresses, hands off results
`default_nettype none

module npcs_ctrl
  import npcs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_command,
  output logic            in_ready,
  input  wire dp_status_t status,
  output ctl_cmd_t        cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_PUBLISH
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] addr;
  logic              accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd               = '0;
    cmd.load_we       = accept && (in_command == CMD_LOAD);
    cmd.query_capture = accept && (in_command == CMD_QUERY);
    cmd.rd_addr       = addr;
    cmd.rd_en         = (state == ST_SCAN);
    cmd.rd_first      = (state == ST_SCAN) && (addr == '0);
    cmd.rd_last       = (state == ST_SCAN) && (addr == status.last_addr);
    cmd.publish       = (state == ST_PUBLISH) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      addr  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          addr <= '0;
          if (accept && (in_command == CMD_QUERY)) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (addr == status.last_addr) begin
            state <= ST_WAIT;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        ST_WAIT: begin
          if (status.scan_done) begin
            state <= ST_PUBLISH;
          end
        end
        ST_PUBLISH: begin
          if (status.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/npcs_dp.sv
// palette memory, squared distance pipeline, running minimum, result register
`default_nettype none

module npcs_dp
  import npcs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ctl_cmd_t           cmd,
  output dp_status_t              status,
  input  wire logic               cfg_we,
  input  wire logic [SIZE_W-1:0]  cfg_wdata,
  input  wire logic [INDEX_W-1:0] entry_index,
  input  wire logic [COLOR_W-1:0] entry_red,
  input  wire logic [COLOR_W-1:0] entry_green,
  input  wire logic [COLOR_W-1:0] entry_blue,
  input  wire logic [COLOR_W-1:0] query_red,
  input  wire logic [COLOR_W-1:0] query_green,
  input  wire logic [COLOR_W-1:0] query_blue,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [INDEX_W-1:0]      nearest_index,
  output logic [DIST_W-1:0]       nearest_distance
);

  logic [ENTRY_W-1:0] palette_mem [PALETTE_DEPTH];

  logic [SIZE_W-1:0]  palette_size;
  logic [ADDR_W-1:0]  last_addr;

  logic [COLOR_W-1:0] q_red;
  logic [COLOR_W-1:0] q_green;
  logic [COLOR_W-1:0] q_blue;

  // stage 1: memory read
  logic [ENTRY_W-1:0] s1_entry;
  logic               s1_valid;
  logic               s1_first;
  logic               s1_last;
  logic [ADDR_W-1:0]  s1_idx;

  // stage 2: squared channel differences
  logic [SQ_W-1:0]    s2_sq_r;
  logic [SQ_W-1:0]    s2_sq_g;
  logic [SQ_W-1:0]    s2_sq_b;
  logic               s2_valid;
  logic               s2_first;
  logic               s2_last;
  logic [ADDR_W-1:0]  s2_idx;

  logic [COLOR_W-1:0] diff_r;
  logic [COLOR_W-1:0] diff_g;
  logic [COLOR_W-1:0] diff_b;
  logic [DIST_W-1:0]  dist_sum;

  logic [DIST_W-1:0]  best_dist;
  logic [ADDR_W-1:0]  best_idx;
  logic               scan_done;

  // size 0 still searches entry 0, large sizes clamp to the store
  always_comb begin
    if (palette_size == '0) begin
      last_addr = '0;
    end else if (palette_size >= SIZE_LIMIT) begin
      last_addr = LAST_MAX;
    end else begin
      last_addr = ADDR_W'(palette_size - 1'b1);
    end
  end

  assign status.scan_done = scan_done;
  assign status.out_free  = !out_valid || out_ready;
  assign status.last_addr = last_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_size <= SIZE_RESET;
    end else if (cfg_we) begin
      palette_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_we && (32'(entry_index) < PALETTE_DEPTH)) begin
      palette_mem[ADDR_W'(entry_index)] <= {entry_red, entry_green, entry_blue};
    end
    if (cmd.rd_en) begin
      s1_entry <= palette_mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_capture) begin
      q_red   <= query_red;
      q_green <= query_green;
      q_blue  <= query_blue;
    end
  end

  always_comb begin
    diff_r = (q_red > s1_entry[23:16]) ? q_red - s1_entry[23:16]
                                        : s1_entry[23:16] - q_red;
    diff_g = (q_green > s1_entry[15:8]) ? q_green - s1_entry[15:8]
                                         : s1_entry[15:8] - q_green;
    diff_b = (q_blue > s1_entry[7:0]) ? q_blue - s1_entry[7:0]
                                       : s1_entry[7:0] - q_blue;
    dist_sum = DIST_W'(s2_sq_r) + DIST_W'(s2_sq_g) + DIST_W'(s2_sq_b);
  end

  always_ff @(posedge clk) begin
    s1_idx  <= cmd.rd_addr;
    s2_idx  <= s1_idx;
    s2_sq_r <= SQ_W'(diff_r) * SQ_W'(diff_r);
    s2_sq_g <= SQ_W'(diff_g) * SQ_W'(diff_g);
    s2_sq_b <= SQ_W'(diff_b) * SQ_W'(diff_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s1_first  <= 1'b0;
      s1_last   <= 1'b0;
      s2_valid  <= 1'b0;
      s2_first  <= 1'b0;
      s2_last   <= 1'b0;
      scan_done <= 1'b0;
    end else begin
      s1_valid  <= cmd.rd_en;
      s1_first  <= cmd.rd_first;
      s1_last   <= cmd.rd_last;
      s2_valid  <= s1_valid;
      s2_first  <= s1_first;
      s2_last   <= s1_last;
      scan_done <= s2_valid && s2_last;
    end
  end

  // strict less-than keeps the lowest index on a tie
  always_ff @(posedge clk) begin
    if (s2_valid && (s2_first || (dist_sum < best_dist))) begin
      best_dist <= dist_sum;
      best_idx  <= s2_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      nearest_index    <= INDEX_W'(best_idx);
      nearest_distance <= best_dist;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/nearest_palette_color_search_unit.sv
// top level of the nearest palette color search unit
`default_nettype none

// channel   dir  handshake            payload
// in_ch     in   valid / ready        command, entry_index, entry_*, query_*
// out_ch    out  valid / ready        nearest_index, nearest_distance
// cfg       in   cfg_we (no ready)    cfg_wdata = palette_size
//
// a load transfer writes one palette entry in a single cycle, no result
// a query scans entries 0 .. min(palette_size, 256) - 1 (at least entry 0)
// through one distance and compare pipe, one entry per cycle, reading
// each entry through the single memory read port
// in_ch.ready is high only between items; a result not yet taken holds the
// next query at its hand-off, and no item, load or query, is taken meanwhile
// rst is synchronous; palette_size resets to 256, palette contents do not

module nearest_palette_color_search_unit
  import npcs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [SIZE_W-1:0] cfg_wdata,
  npcs_in_if.sink                in_ch,
  npcs_out_if.source             out_ch
);

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic       in_ready;

  assign in_ch.ready = in_ready;

  // sequencer: owns the handshake on the input side and the scan address
  npcs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // datapath: palette store, distance pipe, best match, output register
  npcs_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .entry_index      (in_ch.entry_index),
    .entry_red        (in_ch.entry_red),
    .entry_green      (in_ch.entry_green),
    .entry_blue       (in_ch.entry_blue),
    .query_red        (in_ch.query_red),
    .query_green      (in_ch.query_green),
    .query_blue       (in_ch.query_blue),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .nearest_index    (out_ch.nearest_index),
    .nearest_distance (out_ch.nearest_distance)
  );

endmodule

`default_nettype wire

>>> bench/nearest_match_checker.sv
// checker for the palette search unit: tracks the palette, predicts each match and compares
`timescale 1ns / 100ps

module nearest_match_checker
  import npcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  npcs_in_if                in_mon,
  npcs_out_if               out_mon,
  output int                mismatches,
  output int                outstanding
);

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [DIST_W-1:0]  distance;
  } match_t;

  logic [ENTRY_W-1:0] palette [PALETTE_DEPTH];
  logic [SIZE_W-1:0]  search_size;
  match_t             expected_matches [$];

  initial begin
    for (int i = 0; i < PALETTE_DEPTH; i++) palette[i] = '0;
  end

  function automatic int unsigned sq_delta(input logic [COLOR_W-1:0] a,
                                           input logic [COLOR_W-1:0] b);
    int d;
    d = int'(a) - int'(b);
    return d * d;
  endfunction

  // linear scan, strict less-than keeps the lowest index on a tie
  function automatic match_t nearest_match(input logic [ENTRY_W-1:0] probe);
    match_t      best;
    int unsigned count;
    int unsigned d;
    count = 32'(search_size);
    if (count > SEARCH_MAX) count = SEARCH_MAX;
    if (count == 0) count = 1;
    best = '0;
    for (int i = 0; i < count; i++) begin
      d = sq_delta(probe[23:16], palette[i][23:16])
        + sq_delta(probe[15:8], palette[i][15:8])
        + sq_delta(probe[7:0], palette[i][7:0]);
      if (i == 0 || d < best.distance) begin
        best.index    = INDEX_W'(i);
        best.distance = DIST_W'(d);
      end
    end
    return best;
  endfunction

  always @(posedge clk) begin
    match_t want;
    if (rst) begin
      search_size = SIZE_RESET;
      expected_matches.delete();
      mismatches = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_matches.size() == 0) begin
          $display("%0t unexpected match: index %0d distance %0d", $time,
                   out_mon.nearest_index, out_mon.nearest_distance);
          mismatches++;
        end else begin
          want = expected_matches.pop_front();
          if (out_mon.nearest_index !== want.index) begin
            $display("%0t nearest_index mismatch: expected %0d actual %0d", $time,
                     want.index, out_mon.nearest_index);
            mismatches++;
          end
          if (out_mon.nearest_distance !== want.distance) begin
            $display("%0t nearest_distance mismatch: expected %0d actual %0d", $time,
                     want.distance, out_mon.nearest_distance);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.command == CMD_LOAD)
          palette[in_mon.entry_index] = {in_mon.entry_red, in_mon.entry_green,
                                         in_mon.entry_blue};
        else
          expected_matches.push_back(nearest_match({in_mon.query_red, in_mon.query_green,
                                                    in_mon.query_blue}));
      end
      if (cfg_we) search_size = cfg_wdata;
    end
    outstanding <= expected_matches.size();
  end

endmodule

>>> bench/tb.sv
// testbench top: stimulus, handshake timing and verdict for the palette search unit
`timescale 1ns / 100ps

module tb;
  import npcs_pkg::*;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;

  npcs_in_if  in_ch ();
  npcs_out_if out_ch ();

  int mismatches;
  int outstanding;

  // stimulus-side copy of what has been loaded, so queries never touch an unwritten slot
  logic [ENTRY_W-1:0] shadow [PALETTE_DEPTH];
  bit                 loaded [PALETTE_DEPTH];
  int unsigned        active_count;

  // steady: no gaps on either side; hold_req: one long receiver stall
  bit steady;
  bit hold_req;

  nearest_palette_color_search_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  nearest_match_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit, far above the slowest legal run
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // one transfer on the item channel; valid stays up into the next call when there is no gap
  task automatic send_item(input logic cmd, input logic [ADDR_W-1:0] slot,
                           input logic [ENTRY_W-1:0] entry, input logic [ENTRY_W-1:0] probe);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.entry_index <= slot;
    in_ch.entry_red   <= entry[23:16];
    in_ch.entry_green <= entry[15:8];
    in_ch.entry_blue  <= entry[7:0];
    in_ch.query_red   <= probe[23:16];
    in_ch.query_green <= probe[15:8];
    in_ch.query_blue  <= probe[7:0];
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // query fields on a load are noise
  task automatic load_entry(input logic [ADDR_W-1:0] slot, input logic [ENTRY_W-1:0] color);
    shadow[slot] = color;
    loaded[slot] = 1'b1;
    send_item(CMD_LOAD, slot, color, ENTRY_W'($urandom));
  endtask

  // load fields on a query are noise
  task automatic ask(input logic [ENTRY_W-1:0] color);
    send_item(CMD_QUERY, ADDR_W'($urandom), ENTRY_W'($urandom), color);
  endtask

  // channel value biased toward the ends of the range
  function automatic logic [COLOR_W-1:0] pick_channel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  function automatic logic [ENTRY_W-1:0] pick_color();
    return {pick_channel(), pick_channel(), pick_channel()};
  endfunction

  // copies of searched entries give exact hits and ties
  function automatic logic [ENTRY_W-1:0] pick_probe();
    int unsigned k;
    k = $urandom_range(0, active_count - 1);
    if ($urandom_range(0, 2) == 0 && loaded[k]) return shadow[k];
    return pick_color();
  endfunction

  // idle point: input quiet, every match back, then an added margin before returning
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_size(input int unsigned size);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= SIZE_W'(size);
    @(posedge clk);
    cfg_we    <= 1'b0;
    // zero searches entry 0 alone, anything above the depth saturates
    active_count = (size == 0) ? 1 : ((size > SEARCH_MAX) ? SEARCH_MAX : size);
    for (int i = 0; i < active_count; i++)
      if (!loaded[i]) load_entry(ADDR_W'(i), pick_color());
  endtask

  task automatic random_items(input int n);
    logic [ADDR_W-1:0] slot;
    repeat (n) begin
      if ($urandom_range(0, 9) < 6) begin
        ask(pick_probe());
      end else begin
        // half the loads land inside the searched range so they move the answer
        if ($urandom_range(0, 1) == 0) slot = ADDR_W'($urandom_range(0, active_count - 1));
        else slot = ADDR_W'($urandom);
        load_entry(slot, ($urandom_range(0, 3) == 0) ? pick_probe() : pick_color());
      end
    end
  endtask

  // result side: random stall per transfer, plus one long hold when asked
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  initial begin
    int unsigned sizes [12];
    sizes = '{3, 0, 17, 64, 2, 128, 256, 511, 40, 300, 1, 200};
    steady   = 1'b0;
    hold_req = 1'b0;
    active_count = 1;
    for (int i = 0; i < PALETTE_DEPTH; i++) loaded[i] = 1'b0;
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.command     <= CMD_LOAD;
    in_ch.entry_index <= '0;
    in_ch.entry_red   <= '0;
    in_ch.entry_green <= '0;
    in_ch.entry_blue  <= '0;
    in_ch.query_red   <= '0;
    in_ch.query_green <= '0;
    in_ch.query_blue  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // single black entry: zero distance and the largest distance
    set_size(1);
    load_entry(8'd0, 24'h000000);
    ask(24'h000000);
    ask(24'hFFFFFF);

    // size zero still searches entry 0, entry 1 stays out of reach
    set_size(0);
    load_entry(8'd1, 24'hFFFFFF);
    ask(24'hFFFFFF);

    set_size(2);
    ask(24'hFFFFFF);
    ask(24'h000000);

    // identical entries 1 and 2: lowest index wins
    load_entry(8'd2, 24'hFFFFFF);
    set_size(3);
    ask(24'hFFFFFF);
    ask(24'h808080);
    ask(24'h7F7F7F);

    // different colors at equal distance: lowest index wins
    load_entry(8'd3, 24'h020000);
    set_size(4);
    ask(24'h010000);

    // top slot, mixed bit patterns
    load_entry(8'hFF, 24'hA55AFF);
    ask(24'h5AA500);

    foreach (sizes[p]) begin
      set_size(sizes[p]);
      steady = (p == 3);
      if (p == 2) begin
        // receiver holds off while queries keep coming, so the input backs up
        hold_req = 1'b1;
        repeat (8) ask(pick_probe());
      end
      random_items(25);
      steady = 1'b0;
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
